@@ sv/polyline_near_clip_project_top_assert.svh @@
// Assertion macros for the polyline near-clip projector.
// Used by pnc_core; expects clk_i and rst_ni in scope.
`ifndef POLYLINE_NEAR_CLIP_PROJECT_TOP_ASSERT_SVH
`define POLYLINE_NEAR_CLIP_PROJECT_TOP_ASSERT_SVH

// property checked every clock, off during reset
`define PNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// antecedent now, consequent in the next clock
`define PNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pnc_pkg.sv @@
// Shared types, constants and the outcode function of the near-clip projector.
// No dependencies.
package pnc_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int SHADE_W = 32;
  localparam int FAR_W   = 31;
  localparam int NEAR_W  = 17;
  localparam int DVD_W   = 2 * COORD_W + 1;
  localparam int DVS_W   = COORD_W + 1;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [FAR_W-1:0]  FAR_RESET  = FAR_W'(8 << FRAC_W);
  localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(1 << (FRAC_W - 8));

  localparam logic REG_FAR  = 1'b0;
  localparam logic REG_NEAR = 1'b1;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_POINT = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] w;
  } vtx_t;

  typedef struct packed {
    logic [FAR_W-1:0]  far_limit;
    logic [NEAR_W-1:0] near_eff;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [5:0] outcode(vtx_t v, logic [FAR_W-1:0] far_lim,
                                         logic [NEAR_W-1:0] nr);
    logic signed [COORD_W+1:0] xe, ye, we, nw;
    logic signed [COORD_W:0]   ze, fe, w1, ne;
    logic [5:0]                oc;
    xe = {{2{v.x[COORD_W-1]}}, v.x};
    ye = {{2{v.y[COORD_W-1]}}, v.y};
    we = {{2{v.w[COORD_W-1]}}, v.w};
    nw = -we;
    ze = {v.z[COORD_W-1], v.z};
    fe = (COORD_W+1)'(far_lim);
    w1 = {v.w[COORD_W-1], v.w};
    ne = (COORD_W+1)'(nr);
    oc[0] = xe > we;
    oc[1] = xe < nw;
    oc[2] = ye > we;
    oc[3] = ye < nw;
    oc[4] = ze > fe;
    oc[5] = w1 < ne;
    return oc;
  endfunction

endpackage

@@ sv/pnc_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on pnc_pkg for widths and the request/response structs.
module pnc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pnc_pkg::div_req_t req_i,
  output pnc_pkg::div_rsp_t rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [pnc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [pnc_pkg::DVS_W-1:0]   rem_q, rem_d;
  logic [pnc_pkg::DVS_W-1:0]   dvs_q, dvs_d;
  logic [pnc_pkg::DVD_W-1:0]   quo_q, quo_d;
  logic [pnc_pkg::DVS_W:0]     sh, diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    sh     = {rem_q, quo_q[pnc_pkg::DVD_W-1]};
    diff   = sh - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (!diff[pnc_pkg::DVS_W]) begin
        rem_d = diff[pnc_pkg::DVS_W-1:0];
        quo_d = {quo_q[pnc_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = sh[pnc_pkg::DVS_W-1:0];
        quo_d = {quo_q[pnc_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pnc_pkg::CNT_W'(pnc_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ sv/pnc_core.sv @@
// Sequencer and datapath: outcodes, near clipping, projection, output word register.
// Depends on pnc_pkg and drives the shared divider pnc_div through structs.
`include "polyline_near_clip_project_top_assert.svh"

module pnc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pnc_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         first_vertex_i,
  input  logic                         end_fragment_i,
  input  pnc_pkg::vtx_t                vtx_i,
  input  logic [pnc_pkg::SHADE_W-1:0]  shade_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pnc_pkg::kind_e               kind_o,
  output logic [pnc_pkg::COORD_W-1:0]  screen_x_o,
  output logic [pnc_pkg::COORD_W-1:0]  screen_y_o,
  output logic [pnc_pkg::SHADE_W-1:0]  out_shade_o,
  output logic                         last_of_run_o,
  output pnc_pkg::div_req_t            div_req_o,
  input  pnc_pkg::div_rsp_t            div_rsp_i
);

  localparam int CW = pnc_pkg::COORD_W;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_DECIDE = 13'b0000000000010,
    ST_SETUP  = 13'b0000000000100,
    ST_MUL    = 13'b0000000001000,
    ST_CGO    = 13'b0000000010000,
    ST_CWAIT  = 13'b0000000100000,
    ST_PGO    = 13'b0000001000000,
    ST_PWAIT  = 13'b0000010000000,
    ST_EMIT_B = 13'b0000100000000,
    ST_EMIT_P = 13'b0001000000000,
    ST_CLOSE  = 13'b0010000000000,
    ST_TAIL   = 13'b0100000000000,
    ST_FINAL  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  pnc_pkg::vtx_t cur_q, cur_d, prev_q, prev_d;
  logic first_q, first_d, endf_q, endf_d, start_q, start_d;
  logic open_q, open_d, have_prev_q, have_prev_d;
  logic end_q, end_d, k_q, k_d;
  logic [pnc_pkg::SHADE_W-1:0] shin_q, shin_d, held_q, held_d;
  logic [pnc_pkg::DVD_W-1:0] prod_q, prod_d;
  logic [CW:0] num_q, num_d;
  logic [CW-1:0] rx0_q, rx0_d, ry0_q, ry0_d, rx1_q, rx1_d, ry1_q, ry1_d;

  logic ovalid_q, ovalid_d, olast_q, olast_d;
  pnc_pkg::kind_e okind_q, okind_d;
  logic [CW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [pnc_pkg::SHADE_W-1:0] osh_q, osh_d;

  pnc_pkg::vtx_t e_v, o_v;
  logic [CW-1:0] e_k, o_k, owmn_l, sat_v;
  logic signed [CW:0] ek_x, ok_x, d_s, ew_x, ow_x, nr_x, owmn, cden;
  logic [CW:0] absd, absn;
  logic ew_ge, d_neg, ofree, reject;
  logic [pnc_pkg::DVD_W-1:0] prod_w, pdvd, q;
  logic [pnc_pkg::DVS_W-1:0] pdvs;
  logic [CW+2:0] oext, qz, c_w;
  logic [5:0] oc0, oc1;

  always_comb begin
    e_v    = end_q ? cur_q : prev_q;
    o_v    = end_q ? prev_q : cur_q;
    e_k    = k_q ? e_v.y : e_v.x;
    o_k    = k_q ? o_v.y : o_v.x;
    ek_x   = {e_k[CW-1], e_k};
    ok_x   = {o_k[CW-1], o_k};
    ew_x   = {e_v.w[CW-1], e_v.w};
    ow_x   = {o_v.w[CW-1], o_v.w};
    nr_x   = (CW+1)'(cfg_i.near_eff);
    ew_ge  = ew_x >= nr_x;
    d_s    = ek_x - ok_x;
    d_neg  = d_s[CW];
    absd   = d_neg ? -d_s : d_s;
    owmn   = ow_x - nr_x;
    owmn_l = owmn[CW-1:0];
    prod_w = absd * owmn_l;
    cden   = ow_x - ew_x;
    q      = div_rsp_i.quotient;
    oext   = {{2{ok_x[CW]}}, ok_x};
    qz     = (CW+3)'(q[CW:0]);
    c_w    = d_neg ? oext - qz : oext + qz;
    absn   = num_q[CW] ? -num_q : num_q;
    pdvd   = pnc_pkg::DVD_W'(absn) << pnc_pkg::FRAC_W;
    pdvs   = ew_ge ? pnc_pkg::DVS_W'(e_v.w) : pnc_pkg::DVS_W'(cfg_i.near_eff);
    if (num_q[CW]) begin
      if ((|q[pnc_pkg::DVD_W-1:CW]) || (q[CW-1] && (|q[CW-2:0])))
        sat_v = {1'b1, {(CW-1){1'b0}}};
      else
        sat_v = -q[CW-1:0];
    end else begin
      if (|q[pnc_pkg::DVD_W-1:CW-1])
        sat_v = {1'b0, {(CW-1){1'b1}}};
      else
        sat_v = q[CW-1:0];
    end
    oc0    = pnc_pkg::outcode(prev_q, cfg_i.far_limit, cfg_i.near_eff);
    oc1    = pnc_pkg::outcode(cur_q, cfg_i.far_limit, cfg_i.near_eff);
    reject = |(oc0 & oc1);
    ofree  = !ovalid_q || !out_stall_i;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    first_d     = first_q;
    endf_d      = endf_q;
    start_d     = start_q;
    open_d      = open_q;
    have_prev_d = have_prev_q;
    end_d       = end_q;
    k_d         = k_q;
    shin_d      = shin_q;
    held_d      = held_q;
    prod_d      = prod_q;
    num_d       = num_q;
    rx0_d       = rx0_q;
    ry0_d       = ry0_q;
    rx1_d       = rx1_q;
    ry1_d       = ry1_q;
    ovalid_d    = ovalid_q && out_stall_i;
    okind_d     = okind_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    osh_d       = osh_q;
    olast_d     = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cur_d   = vtx_i;
          first_d = first_vertex_i;
          endf_d  = end_fragment_i;
          shin_d  = shade_i;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        end_d = 1'b0;
        k_d   = 1'b0;
        if (first_q || !have_prev_q) begin
          start_d     = 1'b1;
          have_prev_d = 1'b1;
          state_d     = open_q ? ST_CLOSE : ST_TAIL;
        end else begin
          start_d = 1'b0;
          if (reject) state_d = open_q ? ST_CLOSE : ST_TAIL;
          else        state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (ew_ge) begin
          num_d   = ek_x;
          state_d = ST_PGO;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = prod_w;
        state_d = ST_CGO;
      end
      ST_CGO: state_d = ST_CWAIT;
      ST_CWAIT: begin
        if (div_rsp_i.done) begin
          num_d   = c_w[CW:0];
          state_d = ST_PGO;
        end
      end
      ST_PGO: state_d = ST_PWAIT;
      ST_PWAIT: begin
        if (div_rsp_i.done) begin
          case ({end_q, k_q})
            2'b00:   rx0_d = sat_v;
            2'b01:   ry0_d = sat_v;
            2'b10:   rx1_d = sat_v;
            default: ry1_d = sat_v;
          endcase
          if (!k_q) begin
            k_d     = 1'b1;
            state_d = ST_SETUP;
          end else if (!end_q) begin
            end_d   = 1'b1;
            k_d     = 1'b0;
            state_d = ST_SETUP;
          end else begin
            state_d = open_q ? ST_EMIT_P : ST_EMIT_B;
          end
        end
      end
      ST_EMIT_B: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          okind_d  = pnc_pkg::KIND_BEGIN;
          ox_d     = rx0_q;
          oy_d     = ry0_q;
          osh_d    = held_q;
          olast_d  = 1'b0;
          open_d   = 1'b1;
          state_d  = ST_EMIT_P;
        end
      end
      ST_EMIT_P: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          okind_d  = pnc_pkg::KIND_POINT;
          ox_d     = rx1_q;
          oy_d     = ry1_q;
          osh_d    = held_q;
          olast_d  = !endf_q;
          state_d  = ST_TAIL;
        end
      end
      ST_CLOSE: begin
        if (ofree) begin
          ovalid_d = 1'b1;
          okind_d  = pnc_pkg::KIND_END;
          ox_d     = '0;
          oy_d     = '0;
          osh_d    = held_q;
          olast_d  = 1'b1;
          open_d   = 1'b0;
          state_d  = ST_TAIL;
        end
      end
      ST_TAIL: begin
        prev_d = cur_q;
        if (start_q) held_d = shin_q;
        if (endf_q && open_q) begin
          state_d = ST_FINAL;
        end else begin
          if (endf_q) have_prev_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (ofree) begin
          ovalid_d    = 1'b1;
          okind_d     = pnc_pkg::KIND_END;
          ox_d        = '0;
          oy_d        = '0;
          osh_d       = held_q;
          olast_d     = 1'b1;
          open_d      = 1'b0;
          have_prev_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      open_q      <= 1'b0;
      have_prev_q <= 1'b0;
      held_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      open_q      <= open_d;
      have_prev_q <= have_prev_d;
      held_q      <= held_d;
      ovalid_q    <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    first_q <= first_d;
    endf_q  <= endf_d;
    start_q <= start_d;
    end_q   <= end_d;
    k_q     <= k_d;
    shin_q  <= shin_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    rx0_q   <= rx0_d;
    ry0_q   <= ry0_d;
    rx1_q   <= rx1_d;
    ry1_q   <= ry1_d;
    okind_q <= okind_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    osh_q   <= osh_d;
    olast_q <= olast_d;
  end

  always_comb begin
    div_req_o.start    = (state_q == ST_CGO) || (state_q == ST_PGO);
    div_req_o.dividend = (state_q == ST_CGO) ? prod_q : pdvd;
    div_req_o.divisor  = (state_q == ST_CGO) ? cden : pdvs;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = ovalid_q;
  assign kind_o        = okind_q;
  assign screen_x_o    = ox_q;
  assign screen_y_o    = oy_q;
  assign out_shade_o   = osh_q;
  assign last_of_run_o = olast_q;

  `PNC_ASSERT(a_open_has_prev, open_q |-> have_prev_q, "shape open without a previous vertex")
  `PNC_ASSERT_NEXT(a_accept_decide, in_valid_i && !in_stall_o, state_q == ST_DECIDE, "accept did not start decode")
  `PNC_ASSERT(a_div_free, div_req_o.start |-> !div_rsp_i.busy, "divider started while busy")

endmodule

@@ sv/polyline_near_clip_project_top.sv @@
// Top level of the polyline near-clip projector: APB registers, core, shared divider.
// Depends on pnc_pkg, pnc_div and pnc_core.
//
//   channel  dir  handshake             payload
//   in       in   in_valid_i/in_stall_o  first_vertex, end_fragment, vx..vw, shade
//   out      out  out_valid_o/out_stall_i kind, screen_x, screen_y, out_shade, last_of_run
//   apb      in   psel/penable/pready    paddr, pwdata, prdata (far_limit @0, near_plane @4)
//
// Each division runs on the single radix-2 divider (65 quotient bits).
// Segment without clipping: 4 divisions; with a clipped end: 6 divisions plus 2 multiplies.
// One word in work at a time; in_stall_o is high from the cycle after accept until idle.
// A stalled output holds the sequencer in its emit state; reset is asynchronous, active low.
module polyline_near_clip_project_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pnc_pkg::ADDR_W-1:0]    paddr,
  input  logic [pnc_pkg::DATA_W-1:0]    pwdata,
  output logic [pnc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          first_vertex_i,
  input  logic                          end_fragment_i,
  input  logic signed [pnc_pkg::COORD_W-1:0] vx_i,
  input  logic signed [pnc_pkg::COORD_W-1:0] vy_i,
  input  logic signed [pnc_pkg::COORD_W-1:0] vz_i,
  input  logic signed [pnc_pkg::COORD_W-1:0] vw_i,
  input  logic [pnc_pkg::SHADE_W-1:0]   shade_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic signed [pnc_pkg::COORD_W-1:0] screen_x_o,
  output logic signed [pnc_pkg::COORD_W-1:0] screen_y_o,
  output logic [pnc_pkg::SHADE_W-1:0]   out_shade_o,
  output logic                          last_of_run_o
);

  logic [pnc_pkg::FAR_W-1:0]  far_q, far_d;
  logic [pnc_pkg::NEAR_W-1:0] near_q, near_d;
  logic                       wr_en;
  pnc_pkg::cfg_t              cfg;
  pnc_pkg::vtx_t              vtx;
  pnc_pkg::div_req_t          div_req;
  pnc_pkg::div_rsp_t          div_rsp;
  pnc_pkg::kind_e             kind;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    far_d  = far_q;
    near_d = near_q;
    if (wr_en) begin
      if (paddr[2] == pnc_pkg::REG_FAR) far_d  = pwdata[pnc_pkg::FAR_W-1:0];
      else                              near_d = pwdata[pnc_pkg::NEAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_q  <= pnc_pkg::FAR_RESET;
      near_q <= pnc_pkg::NEAR_RESET;
    end else begin
      far_q  <= far_d;
      near_q <= near_d;
    end
  end

  assign prdata = (paddr[2] == pnc_pkg::REG_NEAR) ? pnc_pkg::DATA_W'(near_q)
                                                  : pnc_pkg::DATA_W'(far_q);

  // zero near plane acts as one LSB
  assign cfg.far_limit = far_q;
  assign cfg.near_eff  = (near_q == '0) ? pnc_pkg::NEAR_W'(1) : near_q;

  assign vtx.x = vx_i;
  assign vtx.y = vy_i;
  assign vtx.z = vz_i;
  assign vtx.w = vw_i;

  pnc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_vertex_i (first_vertex_i),
    .end_fragment_i (end_fragment_i),
    .vtx_i          (vtx),
    .shade_i        (shade_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .out_shade_o    (out_shade_o),
    .last_of_run_o  (last_of_run_o),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp)
  );

  pnc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign kind_o = kind;

endmodule
